// ===== rtl/igmp_pkg.sv =====
// Shared types and constants for the IGMP message parser.
// Holds the result record, the IGMP type and kind codes, and the result queue sizing.
// No dependencies.
package igmp_pkg;

    // IGMP type bytes
    localparam logic [7:0] T_QUERY = 8'h11;
    localparam logic [7:0] T_V1REP = 8'h12;
    localparam logic [7:0] T_V2REP = 8'h16;
    localparam logic [7:0] T_LEAVE = 8'h17;
    localparam logic [7:0] T_V3REP = 8'h22;

    // event codes
    localparam logic [1:0] EV_HEADER = 2'd0;
    localparam logic [1:0] EV_RECORD = 2'd1;
    localparam logic [1:0] EV_SOURCE = 2'd2;
    localparam logic [1:0] EV_END    = 2'd3;

    // message kinds
    localparam logic [2:0] K_V1_QUERY  = 3'd0;
    localparam logic [2:0] K_V2_QUERY  = 3'd1;
    localparam logic [2:0] K_V3_QUERY  = 3'd2;
    localparam logic [2:0] K_V1_REPORT = 3'd3;
    localparam logic [2:0] K_V2_REPORT = 3'd4;
    localparam logic [2:0] K_LEAVE     = 3'd5;
    localparam logic [2:0] K_V3_REPORT = 3'd6;
    localparam logic [2:0] K_UNSUPP    = 3'd7;

    // result queue: four entries, two kept free so any byte can be taken
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = 2;
    localparam int RQ_CW    = 3;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [2:0]  msg_kind;
        logic [7:0]  max_resp_code;
        logic [15:0] checksum;
        logic [31:0] address;
        logic        suppress_flag;
        logic [2:0]  robustness;
        logic [7:0]  interval_code;
        logic [15:0] item_count;
        logic [7:0]  record_type;
        logic        truncated;
        logic        run_last;
    } igmp_result_t;

    function automatic logic [2:0] kind_of(input logic [7:0] msg_type,
                                           input logic [7:0] code);
        logic [2:0] k;
        case (msg_type)
            T_QUERY: k = (code == 8'h00) ? K_V1_QUERY : K_V3_QUERY;
            T_V1REP: k = K_V1_REPORT;
            T_V2REP: k = K_V2_REPORT;
            T_LEAVE: k = K_LEAVE;
            T_V3REP: k = K_V3_REPORT;
            default: k = K_UNSUPP;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/igmp_res_queue.sv =====
// Result queue for the IGMP message parser: four registered entries,
// up to two pushes per cycle, at most one pop per cycle while res_stall is low. Depends on igmp_pkg.
module igmp_res_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            push_cnt,
    input  igmp_pkg::igmp_result_t push0,
    input  igmp_pkg::igmp_result_t push1,
    output logic                  room,
    output logic                  res_valid,
    input  logic                  res_stall,
    output igmp_pkg::igmp_result_t head
);

    igmp_pkg::igmp_result_t mem_reg [igmp_pkg::RQ_DEPTH];

    logic [igmp_pkg::RQ_AW-1:0] wr_ptr_reg;
    logic [igmp_pkg::RQ_AW-1:0] wr_ptr_next;
    logic [igmp_pkg::RQ_AW-1:0] wr_ptr_inc;
    logic [igmp_pkg::RQ_AW-1:0] rd_ptr_reg;
    logic [igmp_pkg::RQ_AW-1:0] rd_ptr_next;
    logic [igmp_pkg::RQ_CW-1:0] count_reg;
    logic [igmp_pkg::RQ_CW-1:0] count_next;
    logic                       pop;

    assign res_valid   = (count_reg != '0);
    assign pop         = res_valid && !res_stall;
    assign head        = mem_reg[rd_ptr_reg];
    assign room        = (count_reg <= igmp_pkg::RQ_CW'(igmp_pkg::RQ_DEPTH - 2));
    assign wr_ptr_inc  = igmp_pkg::RQ_AW'(wr_ptr_reg + 1'b1);
    assign wr_ptr_next = igmp_pkg::RQ_AW'(wr_ptr_reg + push_cnt);
    assign rd_ptr_next = igmp_pkg::RQ_AW'(rd_ptr_reg + pop);
    assign count_next  = igmp_pkg::RQ_CW'(count_reg + push_cnt - pop);

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= igmp_pkg::RQ_CW'(igmp_pkg::RQ_DEPTH))
        else $error("result queue overfilled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt != 2'd0) |-> room)
        else $error("push into result queue without room");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt == 2'd0 && !pop) |=> $stable(count_reg) && $stable(rd_ptr_reg))
        else $error("result queue changed with no push or pop");

endmodule

// ===== rtl/igmp_message_parser.sv =====
// IGMP v1/v2/v3 message parser top level: byte-wise header, record and source decode.
// Depends on igmp_pkg and igmp_res_queue.
//
// One message byte is taken per transaction, and a new byte can be taken every cycle.
// Each byte gives zero, one or two results (a header, record or source, and the end
// result on the byte flagged frame_end); they appear at the result port in order, at
// the earliest in the cycle after the byte is taken. Results wait in a four-entry
// queue; the byte side stalls only while fewer than two entries are free, so with the
// result side taking one result per cycle the block sustains one byte per cycle. The
// checksum is passed on as received and is not verified.
module igmp_message_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  event_res,
    output logic [2:0]  msg_kind,
    output logic [7:0]  max_resp_code,
    output logic [15:0] checksum,
    output logic [31:0] address,
    output logic        suppress_flag,
    output logic [2:0]  robustness,
    output logic [7:0]  interval_code,
    output logic [15:0] item_count,
    output logic [7:0]  record_type,
    output logic        truncated,
    output logic        run_last
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_HDR,
        PH_GROUP,
        PH_QEXT,
        PH_QSRC,
        PH_RHDR,
        PH_REC,
        PH_RSRC,
        PH_AUX,
        PH_DONE,
        PH_SKIP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  pos_reg, pos_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  code_reg, code_next;
    logic [15:0] csum_reg, csum_next;
    logic [31:0] acc_reg, acc_next;
    logic [15:0] records_reg, records_next;
    logic [15:0] sources_reg, sources_next;
    logic [9:0]  aux_reg, aux_next;
    logic [15:0] done_reg, done_next;
    logic [11:0] qflags_reg, qflags_next;

    logic                   accept;
    logic                   room;
    logic                   ev_valid;
    logic                   v2;
    logic [1:0]             push_cnt;
    igmp_pkg::igmp_result_t ev_res;
    igmp_pkg::igmp_result_t end_res;
    igmp_pkg::igmp_result_t push0;
    igmp_pkg::igmp_result_t head;

    assign byte_stall = !room;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        type_next    = type_reg;
        code_next    = code_reg;
        csum_next    = csum_reg;
        acc_next     = acc_reg;
        records_next = records_reg;
        sources_next = sources_reg;
        aux_next     = aux_reg;
        done_next    = done_reg;
        qflags_next  = qflags_reg;
        ev_valid     = 1'b0;
        ev_res       = '0;
        end_res      = '0;
        v2           = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                pos_next     = '0;
                code_next    = '0;
                csum_next    = '0;
                acc_next     = '0;
                records_next = '0;
                sources_next = '0;
                aux_next     = '0;
                done_next    = '0;
                qflags_next  = '0;
                type_next    = data_byte;
                phase_next   = PH_HDR;
            end
            PH_HDR:
            begin
                if (pos_reg == 4'd0)
                begin
                    code_next = data_byte;
                    pos_next  = 4'd1;
                end
                else if (pos_reg == 4'd1)
                begin
                    csum_next = {data_byte, 8'h00};
                    pos_next  = 4'd2;
                end
                else
                begin
                    csum_next = csum_reg | {8'h00, data_byte};
                    pos_next  = '0;
                    if (type_reg == igmp_pkg::T_QUERY || type_reg == igmp_pkg::T_V1REP ||
                        type_reg == igmp_pkg::T_V2REP || type_reg == igmp_pkg::T_LEAVE)
                    begin
                        phase_next = PH_GROUP;
                    end
                    else if (type_reg == igmp_pkg::T_V3REP)
                    begin
                        phase_next = PH_RHDR;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_GROUP:
            begin
                acc_next = {acc_reg[23:0], data_byte};
                pos_next = 4'(pos_reg + 1'b1);
                if (pos_reg >= 4'd3)
                begin
                    pos_next = '0;
                    if (type_reg == igmp_pkg::T_QUERY && code_reg != 8'h00 && !frame_end)
                    begin
                        phase_next = PH_QEXT;
                    end
                    else
                    begin
                        // query with nonzero code ending here is v2
                        v2 = (type_reg == igmp_pkg::T_QUERY && code_reg != 8'h00);
                        ev_valid          = 1'b1;
                        ev_res.event_res  = igmp_pkg::EV_HEADER;
                        ev_res.msg_kind   = v2 ? igmp_pkg::K_V2_QUERY
                                               : igmp_pkg::kind_of(type_reg, code_reg);
                        ev_res.address    = acc_next;
                        phase_next        = PH_DONE;
                    end
                end
            end
            PH_QEXT:
            begin
                pos_next = 4'(pos_reg + 1'b1);
                if (pos_reg == 4'd0)
                begin
                    qflags_next = {data_byte[3], data_byte[2:0], 8'h00};
                end
                else if (pos_reg == 4'd1)
                begin
                    qflags_next = qflags_reg | {4'h0, data_byte};
                end
                else if (pos_reg == 4'd2)
                begin
                    sources_next = {data_byte, 8'h00};
                end
                else
                begin
                    sources_next         = sources_reg | {8'h00, data_byte};
                    ev_valid             = 1'b1;
                    ev_res.event_res     = igmp_pkg::EV_HEADER;
                    ev_res.msg_kind      = igmp_pkg::K_V3_QUERY;
                    ev_res.address       = acc_reg;
                    ev_res.suppress_flag = qflags_reg[11];
                    ev_res.robustness    = qflags_reg[10:8];
                    ev_res.interval_code = qflags_reg[7:0];
                    ev_res.item_count    = sources_next;
                    phase_next           = (sources_next != 16'd0) ? PH_QSRC : PH_DONE;
                    pos_next             = '0;
                end
            end
            PH_QSRC, PH_RSRC:
            begin
                acc_next = {acc_reg[23:0], data_byte};
                pos_next = 4'(pos_reg + 1'b1);
                if (pos_reg >= 4'd3)
                begin
                    pos_next         = '0;
                    ev_valid         = 1'b1;
                    ev_res.event_res = igmp_pkg::EV_SOURCE;
                    ev_res.msg_kind  = (phase_reg == PH_QSRC) ? igmp_pkg::K_V3_QUERY
                                                              : igmp_pkg::K_V3_REPORT;
                    ev_res.address   = acc_next;
                    sources_next     = 16'(sources_reg - 1'b1);
                    if (sources_next == 16'd0)
                    begin
                        if (phase_reg == PH_QSRC)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (aux_reg != 10'd0)
                        begin
                            phase_next = PH_AUX;
                        end
                        else if (records_reg != 16'd0)
                        begin
                            phase_next = PH_REC;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
            end
            PH_RHDR:
            begin
                pos_next = 4'(pos_reg + 1'b1);
                if (pos_reg == 4'd2)
                begin
                    records_next = {data_byte, 8'h00};
                end
                else if (pos_reg >= 4'd3)
                begin
                    records_next      = records_reg | {8'h00, data_byte};
                    ev_valid          = 1'b1;
                    ev_res.event_res  = igmp_pkg::EV_HEADER;
                    ev_res.msg_kind   = igmp_pkg::K_V3_REPORT;
                    ev_res.item_count = records_next;
                    phase_next        = (records_next != 16'd0) ? PH_REC : PH_DONE;
                    pos_next          = '0;
                end
            end
            PH_REC:
            begin
                case (pos_reg)
                    4'd0:    qflags_next  = {4'h0, data_byte};
                    4'd1:    aux_next     = {data_byte, 2'b00};
                    4'd2:    sources_next = {data_byte, 8'h00};
                    4'd3:    sources_next = sources_reg | {8'h00, data_byte};
                    default: acc_next     = {acc_reg[23:0], data_byte};
                endcase
                pos_next = 4'(pos_reg + 1'b1);
                if (pos_reg >= 4'd7)
                begin
                    pos_next           = '0;
                    ev_valid           = 1'b1;
                    ev_res.event_res   = igmp_pkg::EV_RECORD;
                    ev_res.msg_kind    = igmp_pkg::K_V3_REPORT;
                    ev_res.address     = acc_next;
                    ev_res.item_count  = sources_next;
                    ev_res.record_type = qflags_next[7:0];
                    records_next       = 16'(records_reg - 1'b1);
                    done_next          = 16'(done_reg + 1'b1);
                    if (sources_next != 16'd0)
                    begin
                        phase_next = PH_RSRC;
                    end
                    else if (aux_next != 10'd0)
                    begin
                        phase_next = PH_AUX;
                    end
                    else if (records_next != 16'd0)
                    begin
                        phase_next = PH_REC;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
            end
            PH_AUX:
            begin
                aux_next = 10'(aux_reg - 1'b1);
                if (aux_next == 10'd0)
                begin
                    pos_next = '0;
                    if (records_reg != 16'd0)
                    begin
                        phase_next = PH_REC;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
            end
            default:
            begin
                // done or unsupported: trailing bytes are ignored
            end
        endcase

        ev_res.max_resp_code = code_next;
        ev_res.checksum      = csum_next;
        ev_res.run_last      = !frame_end;

        end_res.event_res     = igmp_pkg::EV_END;
        end_res.msg_kind      = v2 ? igmp_pkg::K_V2_QUERY
                                   : igmp_pkg::kind_of(type_next, code_next);
        end_res.max_resp_code = code_next;
        end_res.checksum      = csum_next;
        end_res.item_count    = done_next;
        end_res.truncated     = (phase_next != PH_DONE) && (phase_next != PH_SKIP);
        end_res.run_last      = 1'b1;

        if (frame_end)
        begin
            phase_next   = PH_IDLE;
            pos_next     = '0;
            type_next    = '0;
            code_next    = '0;
            csum_next    = '0;
            acc_next     = '0;
            records_next = '0;
            sources_next = '0;
            aux_next     = '0;
            done_next    = '0;
            qflags_next  = '0;
        end
    end

    assign push_cnt = accept ? 2'({1'b0, ev_valid} + {1'b0, frame_end}) : 2'd0;
    assign push0    = ev_valid ? ev_res : end_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            pos_reg     <= '0;
            type_reg    <= '0;
            code_reg    <= '0;
            csum_reg    <= '0;
            acc_reg     <= '0;
            records_reg <= '0;
            sources_reg <= '0;
            aux_reg     <= '0;
            done_reg    <= '0;
            qflags_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            type_reg    <= type_next;
            code_reg    <= code_next;
            csum_reg    <= csum_next;
            acc_reg     <= acc_next;
            records_reg <= records_next;
            sources_reg <= sources_next;
            aux_reg     <= aux_next;
            done_reg    <= done_next;
            qflags_reg  <= qflags_next;
        end
    end

    igmp_res_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push0     (push0),
        .push1     (end_res),
        .room      (room),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .head      (head)
    );

    assign event_res     = head.event_res;
    assign msg_kind      = head.msg_kind;
    assign max_resp_code = head.max_resp_code;
    assign checksum      = head.checksum;
    assign address       = head.address;
    assign suppress_flag = head.suppress_flag;
    assign robustness    = head.robustness;
    assign interval_code = head.interval_code;
    assign item_count    = head.item_count;
    assign record_type   = head.record_type;
    assign truncated     = head.truncated;
    assign run_last      = head.run_last;

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame_end) |=> (phase_reg == PH_IDLE) && (done_reg == 16'd0))
        else $error("parser not back to idle after final byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt == 2'd2) |-> (ev_valid && frame_end))
        else $error("two results from a byte that is not final");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_AUX) |-> (aux_reg != 10'd0))
        else $error("aux skip phase with nothing left to skip");

endmodule

// ===== verif/tb_igmp_message_parser.sv =====
// Testbench for igmp_message_parser: directed and random IGMP messages, one byte per transaction.
// Expected results come from a byte-level parser model kept in the igmp_event_tracker class.
// Depends on rtl/igmp_pkg.sv and rtl/igmp_message_parser.sv.

class igmp_event_tracker;
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_HDR,
        PH_GROUP,
        PH_QEXT,
        PH_QSRC,
        PH_RHDR,
        PH_REC,
        PH_RSRC,
        PH_AUX,
        PH_DONE,
        PH_SKIP
    } parse_phase_t;

    igmp_pkg::igmp_result_t events_due[$];
    int unsigned            failures;
    int unsigned            checked;
    int unsigned            per_event[4];
    int unsigned            cut_short;

    parse_phase_t phase;
    logic [3:0]   pos;
    logic [7:0]   mtype;
    logic [7:0]   code;
    logic [15:0]  csum;
    logic [31:0]  accum;
    logic [15:0]  recs_left;
    logic [15:0]  srcs_left;
    logic [9:0]   aux_left;
    logic [15:0]  recs_done;
    logic [11:0]  qflags;

    function new();
        failures  = 0;
        checked   = 0;
        cut_short = 0;
        foreach (per_event[i])
            per_event[i] = 0;
        clear_parser();
    endfunction

    function void clear_parser();
        phase     = PH_IDLE;
        pos       = '0;
        mtype     = '0;
        code      = '0;
        csum      = '0;
        accum     = '0;
        recs_left = '0;
        srcs_left = '0;
        aux_left  = '0;
        recs_done = '0;
        qflags    = '0;
    endfunction

    function logic [2:0] current_kind();
        if (mtype == igmp_pkg::T_QUERY)
            return (code == 8'h00) ? igmp_pkg::K_V1_QUERY : igmp_pkg::K_V3_QUERY;
        else if (mtype == igmp_pkg::T_V1REP)
            return igmp_pkg::K_V1_REPORT;
        else if (mtype == igmp_pkg::T_V2REP)
            return igmp_pkg::K_V2_REPORT;
        else if (mtype == igmp_pkg::T_LEAVE)
            return igmp_pkg::K_LEAVE;
        else if (mtype == igmp_pkg::T_V3REP)
            return igmp_pkg::K_V3_REPORT;
        return igmp_pkg::K_UNSUPP;
    endfunction

    function igmp_pkg::igmp_result_t blank_event(logic [1:0] ev, logic [2:0] kind);
        igmp_pkg::igmp_result_t r;
        r = '0;
        r.event_res     = ev;
        r.msg_kind      = kind;
        r.max_resp_code = code;
        r.checksum      = csum;
        return r;
    endfunction

    function void close_record();
        pos = '0;
        if (aux_left != 0)
            phase = PH_AUX;
        else if (recs_left != 0)
            phase = PH_REC;
        else
            phase = PH_DONE;
    endfunction

    // advance the parser by one accepted byte and queue what it produces
    function void take_byte(logic [7:0] b, logic fe);
        igmp_pkg::igmp_result_t produced[2];
        int                     n;
        logic                   v2_end;
        logic [2:0]             kind;
        logic                   trunc;
        n      = 0;
        v2_end = 1'b0;
        case (phase)
            PH_IDLE:
            begin
                clear_parser();
                mtype = b;
                phase = PH_HDR;
            end
            PH_HDR:
            begin
                if (pos == 0)
                begin
                    code = b;
                    pos++;
                end
                else if (pos == 1)
                begin
                    csum = {b, 8'h00};
                    pos++;
                end
                else
                begin
                    csum[7:0] = b;
                    if (mtype == igmp_pkg::T_QUERY || mtype == igmp_pkg::T_V1REP ||
                        mtype == igmp_pkg::T_V2REP || mtype == igmp_pkg::T_LEAVE)
                        phase = PH_GROUP;
                    else if (mtype == igmp_pkg::T_V3REP)
                        phase = PH_RHDR;
                    else
                        phase = PH_SKIP;
                    pos = '0;
                end
            end
            PH_GROUP:
            begin
                accum = {accum[23:0], b};
                pos++;
                if (pos >= 4)
                begin
                    pos = '0;
                    if (mtype == igmp_pkg::T_QUERY && code != 8'h00 && !fe)
                    begin
                        phase = PH_QEXT;
                    end
                    else
                    begin
                        // nonzero-code query ending right at the group address is v2
                        v2_end = (mtype == igmp_pkg::T_QUERY && code != 8'h00);
                        kind   = v2_end ? igmp_pkg::K_V2_QUERY : current_kind();
                        produced[n] = blank_event(igmp_pkg::EV_HEADER, kind);
                        produced[n].address = accum;
                        n++;
                        phase = PH_DONE;
                    end
                end
            end
            PH_QEXT:
            begin
                if (pos == 0)
                begin
                    qflags = {b[3], b[2:0], 8'h00};
                    pos++;
                end
                else if (pos == 1)
                begin
                    qflags[7:0] = b;
                    pos++;
                end
                else if (pos == 2)
                begin
                    srcs_left = {b, 8'h00};
                    pos++;
                end
                else
                begin
                    srcs_left[7:0] = b;
                    produced[n] = blank_event(igmp_pkg::EV_HEADER, igmp_pkg::K_V3_QUERY);
                    produced[n].address       = accum;
                    produced[n].suppress_flag = qflags[11];
                    produced[n].robustness    = qflags[10:8];
                    produced[n].interval_code = qflags[7:0];
                    produced[n].item_count    = srcs_left;
                    n++;
                    phase = (srcs_left != 0) ? PH_QSRC : PH_DONE;
                    pos   = '0;
                end
            end
            PH_QSRC, PH_RSRC:
            begin
                accum = {accum[23:0], b};
                pos++;
                if (pos >= 4)
                begin
                    pos  = '0;
                    kind = (phase == PH_QSRC) ? igmp_pkg::K_V3_QUERY : igmp_pkg::K_V3_REPORT;
                    produced[n] = blank_event(igmp_pkg::EV_SOURCE, kind);
                    produced[n].address = accum;
                    n++;
                    srcs_left = srcs_left - 16'd1;
                    if (srcs_left == 0)
                    begin
                        if (phase == PH_QSRC)
                            phase = PH_DONE;
                        else
                            close_record();
                    end
                end
            end
            PH_RHDR:
            begin
                if (pos == 2)
                begin
                    recs_left = {b, 8'h00};
                    pos++;
                end
                else if (pos >= 3)
                begin
                    recs_left[7:0] = b;
                    produced[n] = blank_event(igmp_pkg::EV_HEADER, igmp_pkg::K_V3_REPORT);
                    produced[n].item_count = recs_left;
                    n++;
                    phase = (recs_left != 0) ? PH_REC : PH_DONE;
                    pos   = '0;
                end
                else
                begin
                    pos++;
                end
            end
            PH_REC:
            begin
                if (pos == 0)
                    qflags = {4'h0, b};
                else if (pos == 1)
                    aux_left = {b, 2'b00};
                else if (pos == 2)
                    srcs_left = {b, 8'h00};
                else if (pos == 3)
                    srcs_left[7:0] = b;
                else
                    accum = {accum[23:0], b};
                pos++;
                if (pos >= 8)
                begin
                    pos = '0;
                    produced[n] = blank_event(igmp_pkg::EV_RECORD, igmp_pkg::K_V3_REPORT);
                    produced[n].address     = accum;
                    produced[n].item_count  = srcs_left;
                    produced[n].record_type = qflags[7:0];
                    n++;
                    recs_left = recs_left - 16'd1;
                    recs_done = recs_done + 16'd1;
                    if (srcs_left != 0)
                        phase = PH_RSRC;
                    else
                        close_record();
                end
            end
            PH_AUX:
            begin
                aux_left = aux_left - 10'd1;
                if (aux_left == 0)
                    close_record();
            end
            default:
            begin
            end
        endcase

        if (fe)
        begin
            trunc = (phase != PH_DONE && phase != PH_SKIP);
            kind  = v2_end ? igmp_pkg::K_V2_QUERY : current_kind();
            produced[n] = blank_event(igmp_pkg::EV_END, kind);
            produced[n].item_count = recs_done;
            produced[n].truncated  = trunc;
            n++;
            if (trunc)
                cut_short++;
            clear_parser();
        end

        if (n > 0)
            produced[n - 1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            per_event[produced[i].event_res]++;
            events_due.insert(events_due.size(), produced[i]);
        end
    endfunction

    function string show(igmp_pkg::igmp_result_t r);
        return $sformatf({"ev=%0d kind=%0d code=%h csum=%h addr=%h s=%0d qrv=%0d qqic=%h ",
                          "cnt=%h rtype=%h trunc=%0d last=%0d"},
                         r.event_res, r.msg_kind, r.max_resp_code, r.checksum, r.address,
                         r.suppress_flag, r.robustness, r.interval_code, r.item_count,
                         r.record_type, r.truncated, r.run_last);
    endfunction

    function void match_event(igmp_pkg::igmp_result_t got);
        igmp_pkg::igmp_result_t want;
        string                  diff;
        if (events_due.size() == 0)
        begin
            failures++;
            if (failures <= 10)
                $display("ERROR: result with nothing pending: %s", show(got));
            return;
        end
        want = events_due.pop_front();
        diff = "";
        if (got.event_res !== want.event_res)         diff = {diff, " event_res"};
        if (got.msg_kind !== want.msg_kind)           diff = {diff, " msg_kind"};
        if (got.max_resp_code !== want.max_resp_code) diff = {diff, " max_resp_code"};
        if (got.checksum !== want.checksum)           diff = {diff, " checksum"};
        if (got.address !== want.address)             diff = {diff, " address"};
        if (got.suppress_flag !== want.suppress_flag) diff = {diff, " suppress_flag"};
        if (got.robustness !== want.robustness)       diff = {diff, " robustness"};
        if (got.interval_code !== want.interval_code) diff = {diff, " interval_code"};
        if (got.item_count !== want.item_count)       diff = {diff, " item_count"};
        if (got.record_type !== want.record_type)     diff = {diff, " record_type"};
        if (got.truncated !== want.truncated)         diff = {diff, " truncated"};
        if (got.run_last !== want.run_last)           diff = {diff, " run_last"};
        if (diff != "")
        begin
            failures++;
            if (failures <= 10)
            begin
                $display("ERROR: result %0d differs in%s", checked, diff);
                $display("  expected %s", show(want));
                $display("  actual   %s", show(got));
            end
        end
        checked++;
    endfunction
endclass

module tb_igmp_message_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 5000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_BYTES = 130;
    localparam int END_SETTLE  = 20;

    // type bytes the block does not support
    localparam logic [7:0] T_UNKNOWN_LO  = 8'h00;
    localparam logic [7:0] T_UNKNOWN_HI  = 8'hff;
    localparam logic [7:0] T_UNKNOWN_MID = 8'h30;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        frame_end = 1'b0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [1:0]  event_res;
    logic [2:0]  msg_kind;
    logic [7:0]  max_resp_code;
    logic [15:0] checksum;
    logic [31:0] address;
    logic        suppress_flag;
    logic [2:0]  robustness;
    logic [7:0]  interval_code;
    logic [15:0] item_count;
    logic [7:0]  record_type;
    logic        truncated;
    logic        run_last;

    igmp_event_tracker tracker;
    logic [7:0]        msg_bytes[$];
    int unsigned       bytes_sent = 0;
    int unsigned       msgs_sent = 0;
    int unsigned       send_gap_pct = 0;
    int unsigned       recv_gap_pct = 0;
    logic              long_hold_req = 1'b0;
    int unsigned       quiet_cycles = 0;

    igmp_message_parser dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // message building
    function automatic void add_byte(logic [7:0] v);
        msg_bytes.insert(msg_bytes.size(), v);
    endfunction

    function automatic void put16(logic [15:0] v);
        add_byte(v[15:8]);
        add_byte(v[7:0]);
    endfunction

    function automatic void put32(logic [31:0] v);
        put16(v[31:16]);
        put16(v[15:0]);
    endfunction

    function automatic void put_random(int n);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void trim_to(int n);
        while (msg_bytes.size() > n)
            void'(msg_bytes.pop_back());
    endfunction

    function automatic void start_msg(logic [7:0] mtype, logic [7:0] code);
        msg_bytes.delete();
        add_byte(mtype);
        add_byte(code);
        put16(16'($urandom_range(0, 65535)));
    endfunction

    function automatic void build_group_msg(logic [7:0] mtype, logic [7:0] code,
                                            logic [31:0] grp);
        start_msg(mtype, code);
        put32(grp);
    endfunction

    function automatic void add_query_ext(logic [7:0] flags, logic [7:0] qqic,
                                          logic [15:0] declared, int actual);
        add_byte(flags);
        add_byte(qqic);
        put16(declared);
        repeat (actual) put32($urandom());
    endfunction

    function automatic void add_record(logic [7:0] rtype, logic [7:0] aux_units,
                                       logic [15:0] declared, int actual);
        add_byte(rtype);
        add_byte(aux_units);
        put16(declared);
        put32($urandom());
        repeat (actual) put32($urandom());
        put_random(aux_units * 4);
    endfunction

    // mostly small counts; now and then a large declared count that the message cuts short
    function automatic logic [15:0] pick_count(output int actual);
        logic [15:0] declared;
        if ($urandom_range(0, 99) < 4)
            declared = 16'($urandom_range(0, 65535));
        else
            declared = 16'($urandom_range(0, 4));
        actual = (declared <= 4) ? int'(declared) : int'($urandom_range(0, 4));
        return declared;
    endfunction

    function automatic void build_random_message();
        int          sel;
        int          actual;
        int          recs;
        logic [15:0] declared;
        logic [7:0]  aux_units;
        sel = int'($urandom_range(0, 99));
        if (sel < 10)
        begin
            build_group_msg(igmp_pkg::T_QUERY, 8'h00, $urandom());
        end
        else if (sel < 22)
        begin
            build_group_msg(igmp_pkg::T_QUERY, 8'($urandom_range(1, 255)), $urandom());
        end
        else if (sel < 40)
        begin
            build_group_msg(igmp_pkg::T_QUERY, 8'($urandom_range(0, 255)), $urandom());
            declared = pick_count(actual);
            add_query_ext(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          declared, actual);
        end
        else if (sel < 47)
        begin
            build_group_msg(igmp_pkg::T_V1REP, 8'($urandom_range(0, 255)), $urandom());
        end
        else if (sel < 54)
        begin
            build_group_msg(igmp_pkg::T_V2REP, 8'($urandom_range(0, 255)), $urandom());
        end
        else if (sel < 60)
        begin
            build_group_msg(igmp_pkg::T_LEAVE, 8'($urandom_range(0, 255)), $urandom());
        end
        else if (sel < 88)
        begin
            start_msg(igmp_pkg::T_V3REP, 8'($urandom_range(0, 255)));
            put16(16'($urandom_range(0, 65535)));
            put16(pick_count(recs));
            for (int r = 0; r < recs; r++)
            begin
                declared  = pick_count(actual);
                aux_units = ($urandom_range(0, 99) < 80) ? 8'd0 : 8'($urandom_range(1, 3));
                add_record(8'($urandom_range(0, 255)), aux_units, declared, actual);
            end
        end
        else
        begin
            // noise: any type byte, any short length
            msg_bytes.delete();
            put_random(int'($urandom_range(1, 12)));
        end

        if ($urandom_range(0, 99) < 12 && msg_bytes.size() > 1)
            trim_to(int'($urandom_range(1, msg_bytes.size() - 1)));
        else if ($urandom_range(0, 99) < 10)
            put_random(int'($urandom_range(1, 4)));
    endfunction

    // driving
    task automatic send_message();
        for (int i = 0; i < msg_bytes.size(); i++)
        begin
            while ($urandom_range(0, 99) < send_gap_pct)
            begin
                byte_valid <= 1'b0;
                @(posedge clk);
            end
            byte_valid <= 1'b1;
            data_byte  <= msg_bytes[i];
            frame_end  <= (i == msg_bytes.size() - 1);
            @(posedge clk);
            while (byte_stall)
                @(posedge clk);
        end
        bytes_sent += msg_bytes.size();
        msgs_sent++;
    endtask

    task automatic drain_results();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (tracker.events_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        // messages ending on their type byte
        msg_bytes.delete();
        add_byte(igmp_pkg::T_QUERY);
        send_message();
        msg_bytes.delete();
        add_byte(igmp_pkg::T_V3REP);
        send_message();
        // v1 query, all fields zero
        build_group_msg(igmp_pkg::T_QUERY, 8'h00, 32'h0000_0000);
        msg_bytes[2] = 8'h00;
        msg_bytes[3] = 8'h00;
        send_message();
        // v2 query, all fields ones
        build_group_msg(igmp_pkg::T_QUERY, 8'hff, 32'hffff_ffff);
        msg_bytes[2] = 8'hff;
        msg_bytes[3] = 8'hff;
        send_message();
        // nonzero code, ends inside the group address or on the checksum: v3 kind
        build_group_msg(igmp_pkg::T_QUERY, 8'h01, 32'he000_0001);
        trim_to(5);
        send_message();
        build_group_msg(igmp_pkg::T_QUERY, 8'h80, 32'h0000_0000);
        trim_to(4);
        send_message();
        // v3 queries
        build_group_msg(igmp_pkg::T_QUERY, 8'h64, 32'he000_00fb);
        add_query_ext(8'hff, 8'hff, 16'd2, 2);
        send_message();
        build_group_msg(igmp_pkg::T_QUERY, 8'h0a, $urandom());
        add_query_ext(8'h08, 8'h00, 16'd0, 0);
        put_random(3);
        send_message();
        build_group_msg(igmp_pkg::T_QUERY, 8'h0a, $urandom());
        add_query_ext(8'h07, 8'h7d, 16'hffff, 1);
        send_message();
        // v1 query with bytes past the group address
        build_group_msg(igmp_pkg::T_QUERY, 8'h00, $urandom());
        put_random(4);
        send_message();
        build_group_msg(igmp_pkg::T_V1REP, 8'h00, $urandom());
        send_message();
        build_group_msg(igmp_pkg::T_V2REP, 8'h00, $urandom());
        send_message();
        build_group_msg(igmp_pkg::T_LEAVE, 8'hff, $urandom());
        send_message();
        // v3 report: aux data on the first record, empty second record, trailing bytes
        start_msg(igmp_pkg::T_V3REP, 8'h00);
        put16(16'h0000);
        put16(16'd2);
        add_record(8'hff, 8'd1, 16'd1, 1);
        add_record(8'h00, 8'd0, 16'd0, 0);
        put_random(2);
        send_message();
        start_msg(igmp_pkg::T_V3REP, 8'hff);
        put16(16'hffff);
        put16(16'd0);
        send_message();
        // record count at its top, one record present
        start_msg(igmp_pkg::T_V3REP, 8'h00);
        put16(16'h0000);
        put16(16'hffff);
        add_record(8'h04, 8'd0, 16'd2, 2);
        send_message();
        // longest aux block
        start_msg(igmp_pkg::T_V3REP, 8'h00);
        put16(16'h0000);
        put16(16'd1);
        add_record(8'h01, 8'hff, 16'd0, 0);
        send_message();
        // cut inside a record header
        start_msg(igmp_pkg::T_V3REP, 8'h00);
        put16(16'h0000);
        put16(16'd1);
        add_record(8'h02, 8'd0, 16'd1, 1);
        trim_to(12);
        send_message();
        // unsupported types: with extra bytes, cut in the checksum, ending on the checksum
        start_msg(T_UNKNOWN_LO, 8'h00);
        put_random(2);
        send_message();
        start_msg(T_UNKNOWN_HI, 8'hff);
        trim_to(3);
        send_message();
        start_msg(T_UNKNOWN_MID, 8'h12);
        send_message();
    endtask

    initial
    begin : stimulus
        int unsigned goal;
        tracker = new();
        send_gap_pct = 20;
        recv_gap_pct = 20;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain_results();

        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    send_gap_pct = 35;
                    recv_gap_pct = 70;
                end
                1:
                begin
                    send_gap_pct = 70;
                    recv_gap_pct = 35;
                end
                default:
                begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                end
            endcase
            if (p == 2)
            begin
                // source-heavy report against a stalled result side: fills the queue
                long_hold_req = 1'b1;
                start_msg(igmp_pkg::T_V3REP, 8'h00);
                put16(16'h0000);
                put16(16'd1);
                add_record(8'h05, 8'd0, 16'd40, 40);
                send_message();
            end
            goal = bytes_sent + PHASE_BYTES;
            while (bytes_sent < goal)
            begin
                build_random_message();
                send_message();
            end
            drain_results();
        end

        repeat (END_SETTLE) @(posedge clk);
        if (tracker.events_due.size() != 0)
        begin
            $display("ERROR: %0d results never arrived", tracker.events_due.size());
            tracker.failures += tracker.events_due.size();
        end

        $display("Covered %0d messages in %0d bytes: %0d headers, %0d records, %0d sources,",
                 msgs_sent, bytes_sent, tracker.per_event[igmp_pkg::EV_HEADER],
                 tracker.per_event[igmp_pkg::EV_RECORD], tracker.per_event[igmp_pkg::EV_SOURCE]);
        $display("%0d message ends (%0d cut short); %0d results compared, %0d failures.",
                 tracker.per_event[igmp_pkg::EV_END], tracker.cut_short, tracker.checked,
                 tracker.failures);
        if (tracker.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // result side: random stall, plus one long hold on request
    initial
    begin : result_side
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                res_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                res_stall <= ($urandom_range(0, 99) < recv_gap_pct);
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && byte_valid && !byte_stall)
            tracker.take_byte(data_byte, frame_end);
    end

    always @(posedge clk)
    begin
        igmp_pkg::igmp_result_t got;
        if (rst_n && res_valid && !res_stall)
        begin
            got = {event_res, msg_kind, max_resp_code, checksum, address, suppress_flag,
                   robustness, interval_code, item_count, record_type, truncated, run_last};
            tracker.match_event(got);
        end
    end

    // watchdog: no transaction on either side for too long
    always @(posedge clk)
    begin
        if ((byte_valid && !byte_stall) || (res_valid && !res_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("ERROR: no transaction for %0d cycles", QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ===== igmp_message_parser.f =====
rtl/igmp_pkg.sv
rtl/igmp_res_queue.sv
rtl/igmp_message_parser.sv
verif/tb_igmp_message_parser.sv
